[hdl/elt_pkg.sv]
package elt_pkg;

	// token kinds
	localparam logic [3:0] KIND_IDENT   = 4'd0;
	localparam logic [3:0] KIND_KEYWORD = 4'd1;
	localparam logic [3:0] KIND_NUMBER  = 4'd2;
	localparam logic [3:0] KIND_OP      = 4'd3;
	localparam logic [3:0] KIND_ASSIGN  = 4'd4;
	localparam logic [3:0] KIND_SEMI    = 4'd5;
	localparam logic [3:0] KIND_LPAREN  = 4'd6;
	localparam logic [3:0] KIND_RPAREN  = 4'd7;
	localparam logic [3:0] KIND_UNKNOWN = 4'd8;
	localparam logic [3:0] KIND_EOF     = 4'd9;

	// one token record as it travels through the queue
	typedef struct packed {
		logic [3:0]  kind;
		logic [3:0]  sub_code;
		logic [15:0] start_offset;
		logic [15:0] token_length;
		logic [7:0]  single_char;
		logic        last_of_run;
	} tok_t;

	// write enables from the scanner into the queue
	typedef struct packed {
		logic v0;
		logic v1;
	} push_t;

endpackage

[hdl/elt_front.sv]
module elt_front #(
	parameter int PositionBits = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          room,
	input  logic          command,
	input  logic [7:0]    char_in,
	output elt_pkg::push_t push,
	output elt_pkg::tok_t  tok0,
	output elt_pkg::tok_t  tok1
);
	import elt_pkg::*;

	typedef enum logic [3:0] {
		M_IDLE, M_IDENT, M_NUMBER, M_EQ, M_BANG, M_LT, M_GT, M_AMP, M_PIPE
	} mode_t;

	localparam int KwBytes = 5;

	// operator sub-codes
	localparam logic [3:0] OP_EQ   = 4'd0;
	localparam logic [3:0] OP_NE   = 4'd1;
	localparam logic [3:0] OP_NOT  = 4'd2;
	localparam logic [3:0] OP_LE   = 4'd3;
	localparam logic [3:0] OP_LT   = 4'd4;
	localparam logic [3:0] OP_GE   = 4'd5;
	localparam logic [3:0] OP_GT   = 4'd6;
	localparam logic [3:0] OP_AND  = 4'd7;
	localparam logic [3:0] OP_OR   = 4'd8;
	localparam logic [3:0] OP_ADD  = 4'd9;
	localparam logic [3:0] OP_SUB  = 4'd10;
	localparam logic [3:0] OP_MUL  = 4'd11;
	localparam logic [3:0] OP_DIV  = 4'd12;
	localparam logic [3:0] OP_MOD  = 4'd13;

	// keyword sub-codes
	localparam logic [3:0] KW_PRINT = 4'd0;
	localparam logic [3:0] KW_IF    = 4'd1;
	localparam logic [3:0] KW_WHILE = 4'd2;
	localparam logic [3:0] KW_ELSE  = 4'd3;

	// characters
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_EQ     = "=";
	localparam logic [7:0] CH_BANG   = "!";
	localparam logic [7:0] CH_LT     = "<";
	localparam logic [7:0] CH_GT     = ">";
	localparam logic [7:0] CH_AMP    = "&";
	localparam logic [7:0] CH_PIPE   = "|";
	localparam logic [7:0] CH_PLUS   = "+";
	localparam logic [7:0] CH_MINUS  = "-";
	localparam logic [7:0] CH_STAR   = "*";
	localparam logic [7:0] CH_SLASH  = "/";
	localparam logic [7:0] CH_PCT    = "%";
	localparam logic [7:0] CH_SEMI   = ";";
	localparam logic [7:0] CH_LPAREN = "(";
	localparam logic [7:0] CH_RPAREN = ")";

	// keyword text, first character in the low byte
	localparam logic [39:0] TXT_PRINT = {"t", "n", "i", "r", "p"};
	localparam logic [15:0] TXT_IF    = {"f", "i"};
	localparam logic [39:0] TXT_WHILE = {"e", "l", "i", "h", "w"};
	localparam logic [31:0] TXT_ELSE  = {"e", "s", "l", "e"};

	localparam logic [PositionBits-1:0] PosMax = {PositionBits{1'b1}};

	mode_t                   mode_q;
	logic [PositionBits-1:0] pos_q;
	logic [PositionBits-1:0] start_q;
	logic [PositionBits-1:0] len_q;
	logic [8*KwBytes-1:0]    prefix_q;

	logic [PositionBits+15:0] pos_ext, start_ext, len_ext;
	logic [15:0] pos16, start16, len16;
	logic        accept;
	logic        is_space, is_alpha, is_digit, is_end;
	logic        cont, pair_eq, pair_log;
	logic        kw_hit;
	logic [3:0]  kw_idx;
	logic        close_v, begin_v, a_v, b_v;
	tok_t        close_tok, begin_tok, pair_tok, eof_tok, a_tok, b_tok;
	mode_t       begin_mode;
	logic [PositionBits-1:0] pos_inc, len_inc;

	assign accept = in_valid & room;

	// low 16 bits of the position counters, and their saturating increments
	always_comb begin
		pos_ext   = {16'd0, pos_q};
		start_ext = {16'd0, start_q};
		len_ext   = {16'd0, len_q};
		pos16     = pos_ext[15:0];
		start16   = start_ext[15:0];
		len16     = len_ext[15:0];
		pos_inc   = (pos_q != PosMax) ? pos_q + 1'b1 : pos_q;
		len_inc   = (len_q != PosMax) ? len_q + 1'b1 : len_q;
	end

	// character classes
	always_comb begin
		is_space = (char_in == 8'd32) || (char_in >= 8'd9 && char_in <= 8'd13);
		is_alpha = (char_in >= "a" && char_in <= "z") || (char_in >= "A" && char_in <= "Z");
		is_digit = (char_in >= "0" && char_in <= "9");
		is_end   = command || (char_in == CH_NUL);
	end

	// keyword lookup on the held prefix
	always_comb begin
		kw_hit = 1'b1;
		kw_idx = KW_PRINT;
		if (len_q == PositionBits'(5) && prefix_q[39:0] == TXT_PRINT) begin
			kw_idx = KW_PRINT;
		end else if (len_q == PositionBits'(2) && prefix_q[15:0] == TXT_IF) begin
			kw_idx = KW_IF;
		end else if (len_q == PositionBits'(5) && prefix_q[39:0] == TXT_WHILE) begin
			kw_idx = KW_WHILE;
		end else if (len_q == PositionBits'(4) && prefix_q[31:0] == TXT_ELSE) begin
			kw_idx = KW_ELSE;
		end else begin
			kw_hit = 1'b0;
		end
	end

	// token that the pending scan state closes into
	always_comb begin
		close_v = 1'b1;
		close_tok = '0;
		close_tok.start_offset = start16;
		close_tok.token_length = 16'd1;
		unique case (mode_q)
			M_IDENT: begin
				close_tok.kind = kw_hit ? KIND_KEYWORD : KIND_IDENT;
				close_tok.sub_code = kw_hit ? kw_idx : 4'd0;
				close_tok.token_length = len16;
			end
			M_NUMBER: begin
				close_tok.kind = KIND_NUMBER;
				close_tok.token_length = len16;
			end
			M_EQ: close_tok.kind = KIND_ASSIGN;
			M_BANG: begin
				close_tok.kind = KIND_OP;
				close_tok.sub_code = OP_NOT;
				close_tok.single_char = CH_BANG;
			end
			M_LT: begin
				close_tok.kind = KIND_OP;
				close_tok.sub_code = OP_LT;
				close_tok.single_char = CH_LT;
			end
			M_GT: begin
				close_tok.kind = KIND_OP;
				close_tok.sub_code = OP_GT;
				close_tok.single_char = CH_GT;
			end
			M_AMP: begin
				close_tok.kind = KIND_UNKNOWN;
				close_tok.single_char = CH_AMP;
			end
			M_PIPE: begin
				close_tok.kind = KIND_UNKNOWN;
				close_tok.single_char = CH_PIPE;
			end
			default: close_v = 1'b0;
		endcase
	end

	// start of a new token from the current byte
	always_comb begin
		begin_v = 1'b0;
		begin_mode = M_IDLE;
		begin_tok = '0;
		begin_tok.start_offset = pos16;
		begin_tok.token_length = 16'd1;
		if (is_alpha) begin
			begin_mode = M_IDENT;
		end else if (is_digit) begin
			begin_mode = M_NUMBER;
		end else if (!is_space) begin
			unique case (char_in)
				CH_EQ:   begin_mode = M_EQ;
				CH_BANG: begin_mode = M_BANG;
				CH_LT:   begin_mode = M_LT;
				CH_GT:   begin_mode = M_GT;
				CH_AMP:  begin_mode = M_AMP;
				CH_PIPE: begin_mode = M_PIPE;
				CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_PCT: begin
					begin_v = 1'b1;
					begin_tok.kind = KIND_OP;
					begin_tok.single_char = char_in;
					unique case (char_in)
						CH_PLUS:  begin_tok.sub_code = OP_ADD;
						CH_MINUS: begin_tok.sub_code = OP_SUB;
						CH_STAR:  begin_tok.sub_code = OP_MUL;
						CH_SLASH: begin_tok.sub_code = OP_DIV;
						default:  begin_tok.sub_code = OP_MOD;
					endcase
				end
				CH_SEMI: begin
					begin_v = 1'b1;
					begin_tok.kind = KIND_SEMI;
				end
				CH_LPAREN: begin
					begin_v = 1'b1;
					begin_tok.kind = KIND_LPAREN;
				end
				CH_RPAREN: begin
					begin_v = 1'b1;
					begin_tok.kind = KIND_RPAREN;
				end
				default: begin
					begin_v = 1'b1;
					begin_tok.kind = KIND_UNKNOWN;
					begin_tok.single_char = char_in;
				end
			endcase
		end
	end

	// two-character operators and the end-of-file token
	always_comb begin
		cont = ((mode_q == M_IDENT) && (is_alpha || is_digit)) ||
			((mode_q == M_NUMBER) && is_digit);
		pair_eq = (char_in == CH_EQ) && ((mode_q == M_EQ) || (mode_q == M_BANG) ||
			(mode_q == M_LT) || (mode_q == M_GT));
		pair_log = ((mode_q == M_AMP) && (char_in == CH_AMP)) ||
			((mode_q == M_PIPE) && (char_in == CH_PIPE));
		pair_tok = '0;
		pair_tok.kind = KIND_OP;
		pair_tok.start_offset = start16;
		pair_tok.token_length = 16'd2;
		unique case (mode_q)
			M_EQ:    pair_tok.sub_code = OP_EQ;
			M_BANG:  pair_tok.sub_code = OP_NE;
			M_LT:    pair_tok.sub_code = OP_LE;
			M_GT:    pair_tok.sub_code = OP_GE;
			M_AMP:   pair_tok.sub_code = OP_AND;
			default: pair_tok.sub_code = OP_OR;
		endcase
		eof_tok = '0;
		eof_tok.kind = KIND_EOF;
		eof_tok.start_offset = pos16;
	end

	// pick up to two tokens for this byte, packed to the front
	always_comb begin
		a_v = 1'b0;
		b_v = 1'b0;
		a_tok = close_tok;
		b_tok = begin_tok;
		if (is_end) begin
			a_v = close_v;
			b_v = 1'b1;
			b_tok = eof_tok;
		end else if (cont) begin
			a_v = 1'b0;
		end else if (pair_eq || pair_log) begin
			a_v = 1'b1;
			a_tok = pair_tok;
		end else begin
			a_v = close_v;
			b_v = begin_v;
		end
		tok0 = a_v ? a_tok : b_tok;
		tok1 = b_tok;
		tok0.last_of_run = !(a_v && b_v);
		tok1.last_of_run = 1'b1;
		push.v0 = accept && (a_v || b_v);
		push.v1 = accept && a_v && b_v;
	end

	// scan state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= M_IDLE;
			pos_q    <= '0;
			start_q  <= '0;
			len_q    <= '0;
			prefix_q <= '0;
		end else if (accept) begin
			if (is_end) begin
				mode_q   <= M_IDLE;
				pos_q    <= '0;
				start_q  <= '0;
				len_q    <= '0;
				prefix_q <= '0;
			end else begin
				pos_q <= pos_inc;
				if (cont) begin
					if (mode_q == M_IDENT) begin
						for (int i = 0; i < KwBytes; i++) begin
							if (len_q == PositionBits'(i)) begin
								prefix_q[8*i +: 8] <= char_in;
							end
						end
					end
					len_q <= len_inc;
				end else if (pair_eq || pair_log) begin
					mode_q <= M_IDLE;
				end else begin
					mode_q  <= begin_mode;
					start_q <= pos_q;
					len_q   <= PositionBits'(1);
					if (is_alpha) begin
						prefix_q <= {{(8*KwBytes-8){1'b0}}, char_in};
					end
				end
			end
		end
	end

endmodule

[hdl/elt_queue.sv]
module elt_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  elt_pkg::push_t push,
	input  elt_pkg::tok_t  wdata0,
	input  elt_pkg::tok_t  wdata1,
	output logic           room,
	output logic           nonempty,
	input  logic           pop,
	output elt_pkg::tok_t  rdata
);
	import elt_pkg::*;

	localparam int Depth = 4;
	localparam int PtrBits = $clog2(Depth);

	tok_t               entry_q [Depth];
	logic [PtrBits-1:0] wr_ptr_q, rd_ptr_q, wr_ptr_n1;
	logic [PtrBits:0]   count_q;
	logic [PtrBits:0]   push_cnt, pop_cnt;

	// room for a full two-token burst
	assign room      = count_q <= (PtrBits + 1)'(Depth - 2);
	assign nonempty  = count_q != '0;
	assign rdata     = entry_q[rd_ptr_q];
	assign wr_ptr_n1 = wr_ptr_q + 1'b1;
	assign push_cnt  = (PtrBits + 1)'(push.v0) + (PtrBits + 1)'(push.v1);
	assign pop_cnt   = (PtrBits + 1)'(pop);

	// entry storage
	always_ff @(posedge clk) begin
		if (push.v0) begin
			entry_q[wr_ptr_q] <= wdata0;
		end
		if (push.v1) begin
			entry_q[wr_ptr_n1] <= wdata1;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + push_cnt[PtrBits-1:0];
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + push_cnt - pop_cnt;
		end
	end

endmodule

[hdl/elt_back.sv]
module elt_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          nonempty,
	input  elt_pkg::tok_t rdata,
	output logic          pop,
	output logic          m_tvalid,
	input  logic          m_tready,
	output elt_pkg::tok_t tok
);
	import elt_pkg::*;

	logic valid_q;
	tok_t tok_q;

	// refill the output register when it is empty or being taken
	assign pop      = nonempty && (!valid_q || m_tready);
	assign m_tvalid = valid_q;
	assign tok      = tok_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	// token payload
	always_ff @(posedge clk) begin
		if (pop) begin
			tok_q <= rdata;
		end
	end

endmodule

[hdl/expression_language_tokenizer_unit.sv]
// Streaming lexer for a small expression language. Each input transfer carries one source
// byte (s_tdata) or an end-of-source mark (s_tuser high, or a zero byte); each output
// transfer carries one token, with m_tlast set on the last token caused by an input
// transfer. The block takes one byte per cycle while its four-entry token queue has two
// free slots; s_tready drops when it has fewer. The output register drains one token per
// cycle while m_tready is high, so the second token of a byte that closes one token and
// starts another waits in the queue. A token reaches the output through the queue and the
// output register after the byte that completes it; tokens that need one byte of lookahead
// (names, numbers and a lone = ! < > & |) complete on the following byte, while == != <=
// >= && || complete on their second byte. After end of source the offsets restart at zero.
module expression_language_tokenizer_unit #(
	parameter int POSITION_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // char_in[7:0]
	input  logic        s_tuser,   // command
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // sub_code[3:0], start_offset[19:4],
	                               // token_length[35:20], single_char[43:36], zero[47:44]
	output logic [3:0]  m_tuser,   // kind[3:0]
	output logic        m_tlast
);
	import elt_pkg::*;

	push_t push;
	tok_t  tok0, tok1, q_rdata, out_tok;
	logic  room, nonempty, pop;

	assign s_tready = room;

	// scanner and classifier
	elt_front #(
		.PositionBits(POSITION_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.room     (room),
		.command  (s_tuser),
		.char_in  (s_tdata),
		.push     (push),
		.tok0     (tok0),
		.tok1     (tok1)
	);

	// token queue between scanner and output
	elt_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wdata0   (tok0),
		.wdata1   (tok1),
		.room     (room),
		.nonempty (nonempty),
		.pop      (pop),
		.rdata    (q_rdata)
	);

	// output register
	elt_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.nonempty (nonempty),
		.rdata    (q_rdata),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.tok      (out_tok)
	);

	// pack the token onto the master side
	assign m_tdata = {4'd0, out_tok.single_char, out_tok.token_length,
		out_tok.start_offset, out_tok.sub_code};
	assign m_tuser = out_tok.kind;
	assign m_tlast = out_tok.last_of_run;

endmodule
